// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the MD5 stream hash RTL.
// Included by md5_stream_hash_unit for its concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Flags any clock edge at which the expression holds.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
// Flags any clock edge at which the antecedent holds and the consequent does not.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/md5sh_pkg.sv -----
// Package for the MD5 stream hash: constants, round tables and control structs.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package md5sh_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'h3F;
    localparam logic [6:0] ROUNDS   = 7'd64;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Start and clear requests from the sequencer to the compression core.
    typedef struct packed {
        logic start;
        logic clear;
    } core_ctl_t;

    // Status reported back by the compression core.
    typedef struct packed {
        logic busy;
        logic done;
    } core_sts_t;

    // Left-rotate amount of a round.
    function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // Message word consumed by a round; the round's group offset vanishes modulo 16.
    function automatic logic [3:0] msg_idx(input logic [5:0] rnd);
        logic [3:0] n;
        logic [3:0] g;
        n = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = n;
            2'd1:    g = 4'(n * 4'd5 + 4'd1);
            2'd2:    g = 4'(n * 4'd3 + 4'd5);
            default: g = 4'(n * 4'd7);
        endcase
        return g;
    endfunction

    // Nonlinear mixing function of each group of sixteen rounds.
    function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (grp)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

endpackage

// ----- hw/rtl/md5sh_if.sv -----
// Stream interfaces of the MD5 stream hash: byte input and digest output.
// Plain valid/ready channels; no package dependency.
`timescale 1ns / 1ps

interface md5sh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source(output valid, output data_byte, output has_byte, output last, input ready);
    modport sink(input valid, input data_byte, input has_byte, input last, output ready);
endinterface

interface md5sh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_low;
    logic [63:0] digest_high;

    modport source(output valid, output digest_low, output digest_high, input ready);
    modport sink(input valid, input digest_low, input digest_high, output ready);
endinterface

// ----- hw/rtl/md5_stream_hash_unit.sv -----
// Top level of the MD5 stream hash: byte sequencer, padding and digest output.
// Uses md5sh_pkg, md5sh_if, md5sh_buf, md5sh_core and assert_macros.svh.
//
//   channel   dir  payload                         handshake
//   in_ch     in   data_byte[7:0] has_byte last    valid/ready
//   out_ch    out  digest_low[63:0] digest_high    valid/ready
//
// A byte is accepted whenever in_ch.ready is high. The byte that fills a 64-byte
// block is followed by compression in md5sh_core (64 rounds, one per cycle, each
// reading one message word from the single read port of md5sh_buf, plus the
// chaining add), during which in_ch.ready is low. A transfer marked last starts the
// padding: one byte per cycle (9 to 72 bytes) plus one or two compressions, then
// the digest is loaded into the output register once that register is free. Reset
// is asynchronous and needs no clearing pass; the output register lets a new message
// start while the previous digest still waits on out_ch.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module md5_stream_hash_unit
    import md5sh_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    md5sh_in_if.sink        in_ch,
    md5sh_out_if.source     out_ch
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_COMP = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [5:0]  pos_reg, pos_next;
    logic [23:0] wasm_reg, wasm_next;
    logic [63:0] bitlen_reg, bitlen_next;
    // sent80: the 0x80 marker is in; final: the current block carries the length;
    // close: the message is being closed; fin: the last block has been handed over.
    logic        sent80_reg, sent80_next;
    logic        final_reg, final_next;
    logic        close_reg, close_next;
    logic        fin_reg, fin_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_low_reg, out_low_next;
    logic [63:0] out_high_reg, out_high_next;

    logic        accept;
    logic        put;
    logic [7:0]  put_byte;
    logic [7:0]  pad_byte;
    logic        blk_full;
    logic        buf_we;
    logic [3:0]  buf_raddr;
    logic [31:0] buf_rdata;
    core_ctl_t   core_ctl;
    core_sts_t   core_sts;
    logic [127:0] chain;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // Padding byte: the marker first, then zeros, then the bit length little-endian
    // in the last eight positions of the final block.
    always_comb
    begin
        if (!sent80_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (final_reg && (pos_reg >= LEN_POS))
        begin
            pad_byte = bitlen_reg[{pos_reg[2:0], 3'b000} +: 8];
        end
        else
        begin
            pad_byte = '0;
        end
    end

    always_comb
    begin
        put      = 1'b0;
        put_byte = pad_byte;
        if (state_reg == ST_IDLE)
        begin
            put      = accept && in_ch.has_byte;
            put_byte = in_ch.data_byte;
        end
        else if (state_reg == ST_PAD)
        begin
            put = 1'b1;
        end
    end

    assign blk_full = put && (pos_reg == LAST_POS);
    // Bytes gather into a word; the fourth byte writes the whole word.
    assign buf_we   = put && (pos_reg[1:0] == 2'b11);

    always_comb
    begin
        wasm_next = wasm_reg;
        case (pos_reg[1:0])
            2'd0:    wasm_next[7:0]   = put_byte;
            2'd1:    wasm_next[15:8]  = put_byte;
            2'd2:    wasm_next[23:16] = put_byte;
            default: wasm_next = wasm_reg;
        endcase
        if (!put)
        begin
            wasm_next = wasm_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = put ? pos_reg + 6'd1 : pos_reg;
        bitlen_next    = bitlen_reg;
        sent80_next    = sent80_reg;
        final_next     = final_reg;
        close_next     = close_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_low_next   = out_low_reg;
        out_high_next  = out_high_reg;
        core_ctl       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    close_next = in_ch.last;
                    if (in_ch.has_byte)
                    begin
                        bitlen_next = bitlen_reg + 64'd8;
                    end
                    if (blk_full)
                    begin
                        core_ctl.start = 1'b1;
                        state_next     = ST_COMP;
                    end
                    else if (in_ch.last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (!sent80_reg)
                begin
                    sent80_next = 1'b1;
                    final_next  = (pos_reg < LEN_POS);
                end
                if (blk_full)
                begin
                    // A full block with the length in it ends the message; any
                    // other full block during padding makes the next one final.
                    if (final_reg)
                    begin
                        fin_next = 1'b1;
                    end
                    else
                    begin
                        final_next = 1'b1;
                    end
                    core_ctl.start = 1'b1;
                    state_next     = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (core_sts.done)
                begin
                    if (fin_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (close_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_low_next   = chain[63:0];
                    out_high_next  = chain[127:64];
                    core_ctl.clear = 1'b1;
                    bitlen_next    = '0;
                    sent80_next    = 1'b0;
                    final_next     = 1'b0;
                    close_next     = 1'b0;
                    fin_next       = 1'b0;
                    pos_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            bitlen_reg    <= '0;
            sent80_reg    <= 1'b0;
            final_reg     <= 1'b0;
            close_reg     <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bitlen_reg    <= bitlen_next;
            sent80_reg    <= sent80_next;
            final_reg     <= final_next;
            close_reg     <= close_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wasm_reg     <= wasm_next;
        out_low_reg  <= out_low_next;
        out_high_reg <= out_high_next;
    end

    // Writes happen only while the core is idle, so a round never reads a word
    // that is being written; the write that completes a block goes to the last
    // word while the first round reads word zero.
    md5sh_buf u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (pos_reg[5:2]),
        .wdata ({put_byte, wasm_reg}),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    md5sh_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (core_ctl),
        .sts     (core_sts),
        .rd_addr (buf_raddr),
        .rd_data (buf_rdata),
        .chain   (chain)
    );

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.digest_low  = out_low_reg;
    assign out_ch.digest_high = out_high_reg;

    `ASSERT_NEVER(a_no_write_in_comp, clk, rst_n, buf_we && core_sts.busy, "buffer write during compression")
    `ASSERT_IMPLY(a_done_in_comp, clk, rst_n, core_sts.done, state_reg == ST_COMP, "core done outside compression state")
    `ASSERT_IMPLY(a_done_aligned, clk, rst_n, state_reg == ST_DONE, pos_reg == 6'd0 && sent80_reg && final_reg, "digest taken before padding completed")

endmodule

// ----- hw/rtl/md5sh_buf.sv -----
// Block buffer of the MD5 stream hash: sixteen 32-bit message words.
// One write port, one read port with registered read data; uses md5sh_pkg.
`timescale 1ns / 1ps

module md5sh_buf
    import md5sh_pkg::*;
(
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr,
    output logic [31:0] rdata
);

    logic [31:0] mem [16];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/md5sh_core.sv -----
// MD5 compression core: one round per cycle, chaining words held here.
// Reads message words from md5sh_buf, whose read data is registered; uses md5sh_pkg.
`timescale 1ns / 1ps

module md5sh_core
    import md5sh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  core_ctl_t    ctl,
    output core_sts_t    sts,
    output logic [3:0]   rd_addr,
    input  logic [31:0]  rd_data,
    output logic [127:0] chain
);

    logic        busy_reg, busy_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic [31:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [31:0] h0_reg, h0_next, h1_reg, h1_next, h2_reg, h2_next, h3_reg, h3_next;
    logic [5:0]  cur;
    logic [4:0]  s;
    logic [31:0] sum;
    logic [31:0] rot;
    logic        last_rnd;

    assign cur      = rnd_reg[5:0];
    assign s        = rot_amt(cur);
    assign last_rnd = busy_reg && (rnd_reg == ROUNDS);

    // The address for the next round is issued in the cycle before the round uses its word.
    assign rd_addr = ctl.start ? msg_idx(6'd0) : msg_idx(6'(cur + 6'd1));

    assign sum = a_reg + round_f(cur[5:4], b_reg, c_reg, d_reg) + ROUND_K[cur] + rd_data;
    assign rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));

    always_comb
    begin
        busy_next = busy_reg;
        rnd_next  = rnd_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        h0_next = h0_reg;
        h1_next = h1_reg;
        h2_next = h2_reg;
        h3_next = h3_reg;
        if (ctl.clear)
        begin
            h0_next = INIT_A;
            h1_next = INIT_B;
            h2_next = INIT_C;
            h3_next = INIT_D;
        end
        if (ctl.start)
        begin
            busy_next = 1'b1;
            rnd_next  = '0;
            a_next = h0_reg;
            b_next = h1_reg;
            c_next = h2_reg;
            d_next = h3_reg;
        end
        else if (last_rnd)
        begin
            busy_next = 1'b0;
            h0_next = h0_reg + a_reg;
            h1_next = h1_reg + b_reg;
            h2_next = h2_reg + c_reg;
            h3_next = h3_reg + d_reg;
        end
        else if (busy_reg)
        begin
            a_next = d_reg;
            d_next = c_reg;
            c_next = b_reg;
            b_next = b_reg + rot;
            rnd_next = rnd_reg + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            h0_reg   <= INIT_A;
            h1_reg   <= INIT_B;
            h2_reg   <= INIT_C;
            h3_reg   <= INIT_D;
        end
        else
        begin
            busy_reg <= busy_next;
            rnd_reg  <= rnd_next;
            h0_reg   <= h0_next;
            h1_reg   <= h1_next;
            h2_reg   <= h2_next;
            h3_reg   <= h3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = last_rnd;
    assign chain    = {h3_reg, h2_reg, h1_reg, h0_reg};

endmodule
